@@ design/sip_pkg.sv @@
// Shared types and constants for the stepper indexed positioner.
`default_nettype none

package sip_pkg;

   // Command codes carried by req_op; code 3 is unused and does nothing.
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MOVE = 2'd1,
      OP_ZERO = 2'd2
   } op_type;

   // Move planner decisions handed to the state update.
   typedef struct packed {
      logic in_range;   // target index below the position count
      logic zero_dist;  // target already under the rotor
      logic fwd;        // shortest path runs forward
   } plan_type;

   // Half-step coil pattern, bit0 first winding.
   function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
      logic [3:0] pat;
      case (ph)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

@@ design/stepper_indexed_positioner_core.sv @@
// Top level of the stepper indexed positioner: handshake, state and coil drive.
`default_nettype none

// Half-step positioner for a four-coil stepper. Each request beat is a tick
// (advance one half step toward the pending target), a move (pick a target
// index, plan the shortest signed path; an exact half turn goes forward only
// when the target step is above the current one) or a set-zero (present spot
// becomes position 0, any move stops). Every request beat yields exactly one
// response beat showing the state after it: coil drive, busy flag, last index
// reached and absolute half-step count. Moves to an index at or above N_POS,
// and moves to the index already reached while idle, change nothing. A move
// leaves the coils as they were until the next tick; coils drop to zero when
// a move ends. Rate: one beat per clock sustained while rsp_ready stays high;
// a request is registered, then the whole state update runs combinationally
// into the state registers, which drive the response directly. The state
// update (planner subtract/compare plus step wrap) sets the pace.
// STEPS_REV sets the width of rsp_absolute_step; N_POS is at most 16.

module stepper_indexed_positioner_core
   import sip_pkg::*;
#(
   parameter int STEPS_REV = 8192,
   parameter int N_POS     = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [3:0]                    req_target,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [3:0]                         rsp_coils,
   output logic                               rsp_busy_res,
   output logic [3:0]                         rsp_position,
   output logic [$clog2(STEPS_REV)-1:0]       rsp_absolute_step
);

   localparam int AW = $clog2(STEPS_REV);
   localparam logic [AW-1:0] LAST_STEP = AW'(STEPS_REV - 1);

   // ---------------- input stage ----------------
   logic       in_vld_ff, in_vld_in;
   logic [1:0] op_ff,  op_in;
   logic [3:0] tgt_ff, tgt_in;
   logic       out_vld_ff, out_vld_in;
   logic       adv;   // input stage item moves into the state/response stage

   assign adv       = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;

   always_comb begin
      in_vld_in = in_vld_ff;
      op_in     = op_ff;
      tgt_in    = tgt_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         op_in     = req_op;
         tgt_in    = req_target;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // ---------------- positioner state ----------------
   logic [2:0]    phase_ff,   phase_in;
   logic [AW-1:0] abs_ff,     abs_in;
   logic [3:0]    reached_ff, reached_in;
   logic [3:0]    pending_ff, pending_in;
   logic [AW-1:0] steps_ff,   steps_in;
   logic          fwd_ff,     fwd_in;
   logic [3:0]    coil_ff,    coil_in;
   logic          busy_ff,    busy_in;

   plan_type      plan;
   logic [AW-1:0] plan_steps;

   sip_move_calc #(
      .STEPS_REV (STEPS_REV),
      .N_POS     (N_POS),
      .AW        (AW)
   ) u_move_calc (
      .target   (tgt_ff),
      .abs_step (abs_ff),
      .plan     (plan),
      .steps    (plan_steps)
   );

   always_comb begin
      phase_in   = phase_ff;
      abs_in     = abs_ff;
      reached_in = reached_ff;
      pending_in = pending_ff;
      steps_in   = steps_ff;
      fwd_in     = fwd_ff;
      coil_in    = coil_ff;
      if (adv) begin
         case (op_ff)
            OP_TICK: begin
               // idle ticks are no-ops
               if (steps_ff != '0) begin
                  phase_in = fwd_ff ? phase_ff + 3'd1 : phase_ff - 3'd1;
                  coil_in  = coil_pattern(phase_in);
                  if (fwd_ff) begin
                     abs_in = (abs_ff == LAST_STEP) ? '0 : abs_ff + AW'(1);
                  end else begin
                     abs_in = (abs_ff == '0) ? LAST_STEP : abs_ff - AW'(1);
                  end
                  steps_in = steps_ff - AW'(1);
                  if (steps_ff == AW'(1)) begin
                     reached_in = pending_ff;
                     coil_in    = 4'h0;
                  end
               end
            end
            OP_MOVE: begin
               // skip out-of-range targets and re-requests of the spot we sit on
               if (plan.in_range && !(tgt_ff == reached_ff && steps_ff == '0)) begin
                  if (plan.zero_dist) begin
                     reached_in = tgt_ff;
                     steps_in   = '0;
                     coil_in    = 4'h0;
                  end else begin
                     fwd_in     = plan.fwd;
                     steps_in   = plan_steps;
                     pending_in = tgt_ff;
                  end
               end
            end
            OP_ZERO: begin
               reached_in = 4'h0;
               abs_in     = '0;
               phase_in   = 3'd0;
               steps_in   = '0;
               coil_in    = 4'h0;
            end
            default: begin
            end
         endcase
      end
      busy_in = (steps_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= '0;
         abs_ff     <= '0;
         reached_ff <= '0;
         pending_ff <= '0;
         steps_ff   <= '0;
         fwd_ff     <= 1'b0;
         coil_ff    <= '0;
         busy_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         abs_ff     <= abs_in;
         reached_ff <= reached_in;
         pending_ff <= pending_in;
         steps_ff   <= steps_in;
         fwd_ff     <= fwd_in;
         coil_ff    <= coil_in;
         busy_ff    <= busy_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      tgt_ff <= tgt_in;
   end

   // state only moves when a response slot opens, so it doubles as the
   // response register
   assign rsp_valid         = out_vld_ff;
   assign rsp_coils         = coil_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_position      = reached_ff;
   assign rsp_absolute_step = abs_ff;

`ifndef NO_ASSERTIONS
   a_busy_tracks_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (steps_ff != '0))
      else $error("busy flag out of step with remaining count");

   a_coils_off_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> coil_ff == 4'h0)
      else $error("coils driven with no move running");

   a_abs_in_range: assert property (@(posedge clock) disable iff (reset)
      abs_ff <= LAST_STEP)
      else $error("absolute step beyond one revolution");

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_vld_ff)
      else $error("processed beat produced no response");

   a_state_held_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ready |=> $stable(abs_ff) && $stable(coil_ff))
      else $error("state moved under a stalled response");
`endif

endmodule

`default_nettype wire

@@ design/sip_move_calc.sv @@
// Move planner: target lookup and shortest signed path around the circle.
`default_nettype none

module sip_move_calc
   import sip_pkg::*;
#(
   parameter int STEPS_REV = 8192,
   parameter int N_POS     = 5,
   parameter int AW        = 13
) (
   input  wire logic [3:0]    target,
   input  wire logic [AW-1:0] abs_step,
   output plan_type           plan,
   output logic [AW-1:0]      steps
);

   localparam int DW = AW + 2;
   localparam logic signed [DW-1:0] HALF_S = DW'(STEPS_REV / 2);
   localparam logic signed [DW-1:0] REV_S  = DW'(STEPS_REV);

   // absolute step of each position index
   logic [AW-1:0] pos_abs [16];

   for (genvar k = 0; k < 16; k++) begin : g_pos
      localparam logic [AW-1:0] POS_V = AW'((STEPS_REV * k) / N_POS);
      assign pos_abs[k] = POS_V;
   end

   logic signed [DW-1:0] delta;
   logic signed [DW-1:0] wrapped;
   logic signed [DW-1:0] mag;

   always_comb begin
      delta = $signed({2'b00, pos_abs[target]}) - $signed({2'b00, abs_step});
      if (delta > HALF_S) begin
         wrapped = delta - REV_S;
      end else if (delta < -HALF_S) begin
         wrapped = delta + REV_S;
      end else begin
         wrapped = delta;
      end
      mag = (wrapped < 0) ? -wrapped : wrapped;
   end

   assign steps          = mag[AW-1:0];
   assign plan.in_range  = ({1'b0, target} < 5'(N_POS));
   assign plan.zero_dist = (wrapped == '0);
   assign plan.fwd       = (wrapped > 0);

endmodule

`default_nettype wire

@@ dv/stepper_indexed_positioner_core_test.sv @@
// Self-checking testbench for the stepper indexed positioner core.
`timescale 1ns / 100ps

module stepper_indexed_positioner_core_test;
   import sip_pkg::*;

   localparam int STEPS_REV = 8192;
   localparam int N_POS     = 5;
   localparam int STEP_W    = $clog2(STEPS_REV);
   localparam int HALF_REV  = STEPS_REV / 2;

   // op code 3 has no enum member; it must be a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Half-step coil sequence, element 0 is the rightmost nibble.
   localparam logic [7:0][3:0] COIL_SEQ =
      {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   // Random part size in request beats, not counting unused ops and out-of-range moves.
   localparam int RANDOM_BEATS = 550;

   // Back-pressure profiles, one per stimulus phase.
   typedef enum int {
      FLOW_FREE,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct {
      logic [1:0]    op;
      logic [3:0]    target;
      bit            drain;   // hold this beat until every response is back
      flow_mode_type mode;
   } req_beat_type;

   typedef struct packed {
      logic [3:0]        coils;
      logic              busy;
      logic [3:0]        position;
      logic [STEP_W-1:0] abs_step;
   } status_type;

   // ---------------------------------------------------------------------
   // Clock, reset and DUT ports; every input starts at a known value.
   // ---------------------------------------------------------------------
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_ready;
   logic [1:0]        req_op     = OP_TICK;
   logic [3:0]        req_target = 4'd0;
   logic              rsp_valid;
   logic              rsp_ready  = 1'b0;
   logic [3:0]        rsp_coils;
   logic              rsp_busy_res;
   logic [3:0]        rsp_position;
   logic [STEP_W-1:0] rsp_absolute_step;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   stepper_indexed_positioner_core #(
      .STEPS_REV(STEPS_REV),
      .N_POS    (N_POS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_target       (req_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coils        (rsp_coils),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_position     (rsp_position),
      .rsp_absolute_step(rsp_absolute_step)
   );

   // ---------------------------------------------------------------------
   // Positioner predictor state, cleared like the block after reset.
   // ---------------------------------------------------------------------
   logic [2:0]        rotor_phase   = '0;
   logic [STEP_W-1:0] abs_pos       = '0;
   logic [3:0]        reached_idx   = '0;
   logic [3:0]        pending_idx   = '0;
   logic [STEP_W-1:0] steps_to_go   = '0;
   logic              moving_fwd    = 1'b0;
   logic [3:0]        coil_drive    = '0;

   req_beat_type  pending_beats[$];
   status_type    expected_status[$];
   req_beat_type  launch;
   status_type    seen_status;
   status_type    want_status;
   flow_mode_type fill_mode   = FLOW_FREE;
   flow_mode_type active_flow = FLOW_FREE;
   bit            fill_drain  = 1'b0;
   bit            req_fire    = 1'b0;
   int            mismatches  = 0;
   int            random_count = 0;

   // Applies one request beat to the predictor, returns the status after it.
   function automatic status_type advance_positioner(input logic [1:0] op,
                                                     input logic [3:0] target);
      int delta;
      int tgt_abs;
      if (op == OP_TICK) begin
         // idle tick: nothing moves
         if (steps_to_go != 0) begin
            rotor_phase = moving_fwd ? rotor_phase + 3'd1 : rotor_phase - 3'd1;
            coil_drive  = COIL_SEQ[rotor_phase];
            if (moving_fwd)
               abs_pos = (abs_pos == STEPS_REV - 1) ? '0 : abs_pos + 1'b1;
            else
               abs_pos = (abs_pos == 0) ? STEP_W'(STEPS_REV - 1) : abs_pos - 1'b1;
            steps_to_go = steps_to_go - 1'b1;
            if (steps_to_go == 0) begin
               reached_idx = pending_idx;
               coil_drive  = '0;
            end
         end
      end else if (op == OP_MOVE) begin
         // out of range, or already parked at the target: ignored
         if (int'(target) < N_POS && !(target == reached_idx && steps_to_go == 0)) begin
            tgt_abs = (STEPS_REV * int'(target)) / N_POS;
            delta   = tgt_abs - int'(abs_pos);
            if (delta > HALF_REV)
               delta -= STEPS_REV;
            if (delta < -HALF_REV)
               delta += STEPS_REV;
            if (delta == 0) begin
               // already under the rotor: finish on the spot
               reached_idx = target;
               steps_to_go = '0;
               coil_drive  = '0;
            end else begin
               // a running move is replaced; coils hold until the next tick
               moving_fwd  = delta > 0;
               steps_to_go = STEP_W'(delta > 0 ? delta : -delta);
               pending_idx = target;
            end
         end
      end else if (op == OP_ZERO) begin
         // pending index and direction survive a set-zero
         reached_idx = '0;
         abs_pos     = '0;
         rotor_phase = '0;
         steps_to_go = '0;
         coil_drive  = '0;
      end
      return '{coils: coil_drive, busy: steps_to_go != 0, position: reached_idx,
               abs_step: abs_pos};
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic queue_beat(input logic [1:0] op, input logic [3:0] target);
      pending_beats.push_back('{op: op, target: target, drain: fill_drain,
                                mode: fill_mode});
      fill_drain = 1'b0;
      // unused op codes and out-of-range moves don't count toward the random budget
      if (!(op == OP_UNUSED || (op == OP_MOVE && int'(target) >= N_POS)))
         random_count++;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_beat(OP_TICK, 4'($urandom_range(15)));
   endtask

   // Well-formed excursion: zero, one to three moves with a few ticks each
   // (later moves replace the running one), then a move back to index 0 and
   // enough ticks to finish it, so the move completes and the coils drop.
   task automatic queue_excursion();
      int legs;
      int net;
      int k;
      int t;
      net  = 0;
      legs = $urandom_range(1, 3);
      queue_beat(OP_ZERO, 4'($urandom_range(15)));
      repeat (legs) begin
         t = $urandom_range(1, N_POS - 1);
         k = $urandom_range(0, 12);
         queue_beat(OP_MOVE, 4'(t));
         queue_ticks(k);
         // near step 0 the path direction depends only on the target index
         net += ((STEPS_REV * t) / N_POS <= HALF_REV) ? k : -k;
      end
      queue_beat(OP_MOVE, 4'd0);
      queue_ticks((net < 0 ? -net : net) + $urandom_range(0, 3));
   endtask

   // Noise: any op, any target, which also breaks moves off midway.
   task automatic queue_noise();
      repeat ($urandom_range(1, 6))
         queue_beat(2'($urandom_range(3)), 4'($urandom_range(15)));
   endtask

   // ---------------------------------------------------------------------
   // Request driver: launches beats at the falling edge, holds valid and
   // payload steady until the beat is taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_beats.size() != 0
             && !(pending_beats[0].drain && expected_status.size() != 0)
             && $urandom_range(99) >= ((pending_beats[0].mode == FLOW_SEND_GAPS) ? 73 :
                                       (pending_beats[0].mode == FLOW_BOTH) ? 31 : 0)) begin
            launch = pending_beats.pop_front();
            req_op      <= launch.op;
            req_target  <= launch.target;
            req_valid   <= 1'b1;
            active_flow <= launch.mode;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= $urandom_range(99) >= ((active_flow == FLOW_RECV_STALLS) ? 73 :
                                             (active_flow == FLOW_BOTH) ? 31 : 0);
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on every accepted request beat, checks every
   // accepted response beat against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (req_fire)
         expected_status.push_back(advance_positioner(req_op, req_target));
      if (!reset && rsp_valid && rsp_ready) begin
         seen_status = '{coils: rsp_coils, busy: rsp_busy_res, position: rsp_position,
                         abs_step: rsp_absolute_step};
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with none pending: coils=%h busy=%b pos=%0d abs=%0d",
                        $realtime, rsp_coils, rsp_busy_res, rsp_position, rsp_absolute_step);
         end else begin
            want_status = expected_status.pop_front();
            if (seen_status !== want_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch coils %h/%h busy %b/%b pos %0d/%0d abs %0d/%0d (exp/act)",
                           $realtime, want_status.coils, seen_status.coils,
                           want_status.busy, seen_status.busy,
                           want_status.position, seen_status.position,
                           want_status.abs_step, seen_status.abs_step);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      // Directed part, no back-pressure.
      queue_beat(OP_TICK, 4'd15);      // tick while idle
      queue_beat(OP_MOVE, 4'd7);       // target out of range
      queue_beat(OP_MOVE, 4'd15);
      queue_beat(OP_MOVE, 4'd8);
      queue_beat(OP_MOVE, 4'd0);       // already there, idle
      queue_beat(OP_UNUSED, 4'd10);    // unused op code
      queue_beat(OP_MOVE, 4'd4);       // backward path, wraps below step 0
      queue_ticks(3);
      queue_beat(OP_MOVE, 4'd3);       // move while busy replaces the move
      queue_beat(OP_MOVE, 4'd0);       // back forward across the wrap
      queue_ticks(4);                  // last one lands on an idle block
      queue_beat(OP_MOVE, 4'd1);
      queue_beat(OP_MOVE, 4'd0);       // zero distance while busy
      queue_beat(OP_MOVE, 4'd2);       // exact-ish half-turn side, forward
      queue_ticks(2);
      queue_beat(OP_ZERO, 4'd5);       // set zero mid-move
      queue_beat(OP_TICK, 4'd0);       // idle after zero
      queue_beat(OP_MOVE, 4'd0);       // ignored after zero

      // Random part in four back-pressure phases; each phase opens by
      // letting the response side drain completely.
      random_count = 0;
      for (int m = 0; m < 4; m++) begin
         fill_mode  = flow_mode_type'(m);
         fill_drain = 1'b1;
         while (random_count < (m + 1) * RANDOM_BEATS / 4) begin
            if ($urandom_range(99) < 80)
               queue_excursion();
            else
               queue_noise();
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      // let the block settle before the final check
      repeat (8) @(posedge clock);

      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1_600_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
design/sip_pkg.sv
design/sip_move_calc.sv
design/stepper_indexed_positioner_core.sv
dv/stepper_indexed_positioner_core_test.sv
